@@ sv/tarhv_pkg.sv @@
package tarhv_pkg;

   // Field widths of the header parse.
   localparam int POS_W   = 9;
   localparam int SUM_W   = 17;
   localparam int CSUM_W  = 11;
   localparam int CHK_W   = 22;
   localparam int SIZE_W  = 34;
   localparam int MODE_W  = 22;
   localparam int TIME_W  = 36;
   localparam int MTIME_W = 37;

   // Byte offsets of the header fields (end offsets are exclusive).
   localparam logic [POS_W-1:0] POS_NAME_END   = 9'd100;
   localparam logic [POS_W-1:0] POS_MODE_END   = 9'd107;
   localparam logic [POS_W-1:0] POS_SIZE_BEGIN = 9'd124;
   localparam logic [POS_W-1:0] POS_SIZE_END   = 9'd135;
   localparam logic [POS_W-1:0] POS_TIME_BEGIN = 9'd136;
   localparam logic [POS_W-1:0] POS_CHK_BEGIN  = 9'd148;
   localparam logic [POS_W-1:0] POS_CHK_DIGITS = 9'd155;
   localparam logic [POS_W-1:0] POS_LINK       = 9'd156;
   localparam logic [POS_W-1:0] POS_LAST       = 9'd511;

   // Characters that the parser and the verdict look for.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   // The checksum field counts as eight spaces.
   localparam logic [SUM_W:0] CHK_SPACE_SUM = 18'd256;

   // Mode bit that marks a directory.
   localparam int MODE_DIR_BIT = 14;

   // Result status codes.
   localparam logic [1:0] STATUS_VALID    = 2'd0;
   localparam logic [1:0] STATUS_END      = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;
   localparam logic [1:0] STATUS_LINK     = 2'd3;

   // Everything the verdict needs once the last byte of a block is in.
   typedef struct packed {
      logic [SUM_W-1:0]  block_sum;
      logic [CSUM_W-1:0] check_field_sum;
      logic [CHK_W-1:0]  stored_check;
      logic [7:0]        link_type;
      logic [SIZE_W-1:0] size;
      logic              mode_dir;
      logic [7:0]        last_name_char;
      logic [TIME_W-1:0] time_accum;
      logic              time_negative;
   } tarhv_summary_type;

endpackage

@@ sv/tarhv_req_if.sv @@
interface tarhv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] hdr_byte;

   modport source (output valid, output hdr_byte, input ready);
   modport sink (input valid, input hdr_byte, output ready);
endinterface

@@ sv/tarhv_rsp_if.sv @@
interface tarhv_rsp_if;
   import tarhv_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [SIZE_W-1:0]         file_size;
   logic signed [MTIME_W-1:0] mod_time;
   logic                      is_directory;

   modport source (output valid, output status, output file_size, output mod_time,
                   output is_directory, input ready);
   modport sink (input valid, input status, input file_size, input mod_time,
                 input is_directory, output ready);
endinterface

@@ sv/tarhv_field_parse.sv @@
module tarhv_field_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         consume,
   input  logic [7:0]                   hdr_byte,
   output logic                         last_byte,
   output tarhv_pkg::tarhv_summary_type summary
);
   import tarhv_pkg::*;

   // Phases of the mtime parse.
   localparam logic [1:0] TP_SKIP   = 2'd0;
   localparam logic [1:0] TP_SIGN   = 2'd1;
   localparam logic [1:0] TP_DIGITS = 2'd2;
   localparam logic [1:0] TP_STOP   = 2'd3;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CSUM_W-1:0] csum_ff, csum_in;
   logic [CHK_W-1:0]  chk_ff, chk_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [1:0]        phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic              name_end_ff, name_end_in;
   logic [7:0]        last_ch_ff, last_ch_in;
   logic [7:0]        link_ff, link_in;

   logic              is_white;
   logic              is_oct;
   logic [SIZE_W-1:0] size_oct;
   logic [SIZE_W-1:0] mode_oct;
   logic [SIZE_W-1:0] chk_oct;

   // Loose octal step: any decimal digit is ORed in after a shift by three.
   function automatic logic [SIZE_W-1:0] loose_octal(input logic [SIZE_W-1:0] acc,
                                                     input logic [7:0] c);
      logic [SIZE_W-1:0] shifted;
      begin
         shifted = {acc[SIZE_W-4:0], 3'b000};
         if (c >= CH_ZERO && c <= CH_NINE) begin
            loose_octal = shifted | SIZE_W'(c - CH_ZERO);
         end else begin
            loose_octal = acc;
         end
      end
   endfunction

   assign last_byte = (pos_ff == POS_LAST);
   assign is_white  = (hdr_byte == CH_SPACE) || (hdr_byte >= CH_TAB && hdr_byte <= CH_CR);
   assign is_oct    = (hdr_byte >= CH_ZERO) && (hdr_byte <= CH_SEVEN);
   assign size_oct  = loose_octal(size_ff, hdr_byte);
   assign mode_oct  = loose_octal(SIZE_W'(mode_ff), hdr_byte);
   assign chk_oct   = loose_octal(SIZE_W'(chk_ff), hdr_byte);

   // Per-byte update of the running sum and the field being passed.
   always_comb begin
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      csum_in     = csum_ff;
      chk_in      = chk_ff;
      size_in     = size_ff;
      mode_in     = mode_ff;
      time_in     = time_ff;
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      name_end_in = name_end_ff;
      last_ch_in  = last_ch_ff;
      link_in     = link_ff;
      if (consume) begin
         pos_in = pos_ff + 1'b1;
         sum_in = sum_ff + SUM_W'(hdr_byte);
         if (pos_ff < POS_NAME_END) begin
            if (!name_end_ff) begin
               if (hdr_byte == CH_NUL) begin
                  name_end_in = 1'b1;
               end else begin
                  last_ch_in = hdr_byte;
               end
            end
         end else if (pos_ff < POS_MODE_END) begin
            mode_in = mode_oct[MODE_W-1:0];
         end else if (pos_ff >= POS_SIZE_BEGIN && pos_ff < POS_SIZE_END) begin
            size_in = size_oct;
         end else if (pos_ff >= POS_TIME_BEGIN && pos_ff < POS_CHK_BEGIN) begin
            // Signed octal after white space; the first other character stops it.
            if (phase_ff == TP_SKIP && is_white) begin
               phase_in = phase_ff;
            end else if (phase_ff == TP_SKIP &&
                         (hdr_byte == CH_PLUS || hdr_byte == CH_MINUS)) begin
               neg_in   = (hdr_byte == CH_MINUS);
               phase_in = TP_SIGN;
            end else if (phase_ff == TP_STOP) begin
               phase_in = phase_ff;
            end else if (is_oct) begin
               time_in  = {time_ff[TIME_W-4:0], hdr_byte[2:0]};
               phase_in = TP_DIGITS;
            end else begin
               phase_in = TP_STOP;
            end
         end else if (pos_ff >= POS_CHK_BEGIN && pos_ff < POS_LINK) begin
            csum_in = csum_ff + CSUM_W'(hdr_byte);
            if (pos_ff < POS_CHK_DIGITS) begin
               chk_in = chk_oct[CHK_W-1:0];
            end
         end else if (pos_ff == POS_LINK) begin
            link_in = hdr_byte;
         end
         // The last byte closes the block and starts the next one clean.
         if (last_byte) begin
            sum_in      = '0;
            csum_in     = '0;
            chk_in      = '0;
            size_in     = '0;
            mode_in     = '0;
            time_in     = '0;
            phase_in    = TP_SKIP;
            neg_in      = 1'b0;
            name_end_in = 1'b0;
            last_ch_in  = '0;
            link_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         csum_ff     <= '0;
         chk_ff      <= '0;
         size_ff     <= '0;
         mode_ff     <= '0;
         time_ff     <= '0;
         phase_ff    <= TP_SKIP;
         neg_ff      <= 1'b0;
         name_end_ff <= 1'b0;
         last_ch_ff  <= '0;
         link_ff     <= '0;
      end else begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         csum_ff     <= csum_in;
         chk_ff      <= chk_in;
         size_ff     <= size_in;
         mode_ff     <= mode_in;
         time_ff     <= time_in;
         phase_ff    <= phase_in;
         neg_ff      <= neg_in;
         name_end_ff <= name_end_in;
         last_ch_ff  <= last_ch_in;
         link_ff     <= link_in;
      end
   end

   // The last byte lies outside every field, so only the sum takes it in.
   always_comb begin
      summary.block_sum       = sum_ff + SUM_W'(hdr_byte);
      summary.check_field_sum = csum_ff;
      summary.stored_check    = chk_ff;
      summary.link_type       = link_ff;
      summary.size            = size_ff;
      summary.mode_dir        = mode_ff[MODE_DIR_BIT];
      summary.last_name_char  = last_ch_ff;
      summary.time_accum      = time_ff;
      summary.time_negative   = neg_ff;
   end

endmodule

@@ sv/tarhv_verdict.sv @@
module tarhv_verdict (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  tarhv_pkg::tarhv_summary_type summary,
   output logic                         slot_free,
   tarhv_rsp_if.source                  rsp
);
   import tarhv_pkg::*;

   logic [SUM_W:0]     computed;
   logic               chk_match;
   logic               link_ok;
   logic [1:0]         status_in, status_ff;
   logic [SIZE_W-1:0]  size_in, size_ff;
   logic [MTIME_W-1:0] mtime_in, mtime_ff;
   logic               dir_in, dir_ff;
   logic               valid_ff;

   // Checksum with the checksum field counted as spaces.
   assign computed  = {1'b0, summary.block_sum} - (SUM_W + 1)'(summary.check_field_sum)
                      + CHK_SPACE_SUM;
   assign chk_match = (summary.stored_check == CHK_W'(computed));
   assign link_ok   = (summary.link_type == CH_ZERO) || (summary.link_type == CH_NUL);

   // Status priority and the payload of a valid entry.
   always_comb begin
      size_in  = '0;
      mtime_in = '0;
      dir_in   = 1'b0;
      if (summary.block_sum == '0) begin
         status_in = STATUS_END;
      end else if (!chk_match) begin
         status_in = STATUS_MISMATCH;
      end else if (!link_ok) begin
         status_in = STATUS_LINK;
      end else begin
         status_in = STATUS_VALID;
         size_in   = summary.size;
         if (summary.time_negative) begin
            mtime_in = MTIME_W'(0) - {1'b0, summary.time_accum};
         end else begin
            mtime_in = {1'b0, summary.time_accum};
         end
         dir_in = summary.mode_dir || (summary.last_name_char == CH_SLASH) ||
                  (summary.last_name_char == CH_BSLASH);
      end
   end

   // Result register; it reloads in the cycle it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         size_ff   <= size_in;
         mtime_ff  <= mtime_in;
         dir_ff    <= dir_in;
      end
   end

   assign slot_free        = !valid_ff || rsp.ready;
   assign rsp.valid        = valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.file_size    = size_ff;
   assign rsp.mod_time     = $signed(mtime_ff);
   assign rsp.is_directory = dir_ff;

endmodule

@@ sv/tar_header_validator.sv @@
// The result of a block is registered: its last byte passes the input register, and the
// verdict is loaded into the result register when that byte is parsed.
// One header byte per cycle when unstalled.
// The input register frees itself in the cycle it is parsed; only a full result register
// stalls the last byte of a block.
// Reset is synchronous and clears the byte position, all field accumulators and both
// valid flags; the first byte after reset is offset 0 of a new block.
module tar_header_validator (
   input  logic       clock,
   input  logic       reset,
   tarhv_req_if.sink  req,
   tarhv_rsp_if.source rsp
);
   import tarhv_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              req_take;
   logic              consume;
   logic              last_byte;
   logic              slot_free;
   logic              rsp_load;
   tarhv_summary_type summary;

   // Input register: a byte is parsed unless it closes a block and the result is stuck.
   assign consume   = in_valid_ff && (!last_byte || slot_free);
   assign req.ready = !in_valid_ff || consume;
   assign req_take  = req.valid && req.ready;
   assign rsp_load  = consume && last_byte;

   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         byte_in     = req.hdr_byte;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // Field parse and running checksum.
   tarhv_field_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .consume   (consume),
      .hdr_byte  (byte_ff),
      .last_byte (last_byte),
      .summary   (summary)
   );

   // Verdict and result register.
   tarhv_verdict u_verdict (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .summary   (summary),
      .slot_free (slot_free),
      .rsp       (rsp)
   );

   // A new result never overwrites one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp.valid || rsp.ready))
      else $error("result register overwritten");

   // Parsing the last byte of a block always shows a result next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp.valid)
      else $error("block closed without a result");

   // Only a valid entry carries payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != STATUS_VALID) |->
      (rsp.file_size == '0 && rsp.mod_time == '0 && !rsp.is_directory))
      else $error("payload set on a rejected block");

endmodule
